// ===== rtl/rid_pkg.sv =====
package rid_pkg;

	// sample field, twiddle and result widths
	localparam int SAMPLE_W = 16;
	localparam int TW_W     = 16;
	localparam int OUT_W    = 23;
	localparam int BIN_W    = 6;

	// final scaling of the sums
	localparam int FRAC_BITS = 15;

	// cosine rom: 64 entries over one full turn
	localparam int ROM_AW   = 6;
	localparam int ROM_SIZE = 64;

	// defaults for the top-level parameters
	localparam int POINTS_DEF      = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic [ROM_AW-1:0] ROM_QTR   = 6'd16;
	localparam logic [ROM_AW-1:0] ROM_HALF  = 6'd32;
	localparam logic [ROM_AW-1:0] ROM_3QTR  = 6'd48;

	localparam logic signed [TW_W:0] TW_MAX = 17'sd32767;

	// round(32768*cos(2*pi*m/64)) over the first quadrant
	localparam logic signed [TW_W:0] QUARTER_COS [17] = '{
		17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
		17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
		17'sd12540, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
	};

	// q1.15 cosine of 2*pi*m/64, folded from the quarter table, +1.0 saturated
	function automatic logic signed [TW_W-1:0] twiddle_cos(input logic [ROM_AW-1:0] m);
		logic [ROM_AW-1:0] fold;
		logic [4:0] qi;
		logic neg;
		logic signed [TW_W:0] mag;
		logic signed [TW_W:0] v;
		priority if (m <= ROM_QTR) begin
			fold = m;
			neg  = 1'b0;
		end else if (m <= ROM_HALF) begin
			fold = ROM_HALF - m;
			neg  = 1'b1;
		end else if (m <= ROM_3QTR) begin
			fold = m - ROM_HALF;
			neg  = 1'b1;
		end else begin
			fold = '0 - m;
			neg  = 1'b0;
		end
		qi  = fold[4:0];
		mag = QUARTER_COS[qi];
		v   = neg ? -mag : mag;
		if (v > TW_MAX) begin
			v = TW_MAX;
		end
		return v[TW_W-1:0];
	endfunction

endpackage

// ===== rtl/real_input_dft.sv =====
// direct dft of a block of real samples
// input channel: one signed q15 sample per beat (sample_valid / sample_stall),
// in time order; the low SAMPLE_BITS bits are taken (zero-extended if wider).
// after the POINTS-th sample of a block the block computes every bin with
// one complex multiply-accumulate pair (one cos and one -sin product per
// cycle while the pipeline is not frozen) and emits one beat per bin on the result channel
// (result_valid / result_stall), bins in order, final_bin on the last one.
// the sample store is written at one port and read at one port.
// compute: the terms of each bin pass the three stages (store read / rom,
// multiply, accumulate) before the finished bin enters the result register.
// sample_stall is high while the bins of a block are being issued; the next
// block may start loading as soon as the last term has been issued.
// when the result register is full and result_stall is high the whole
// multiply-accumulate pipeline freezes, so no bin is lost or repeated.
// reset (arst_n low) empties the pipeline and the result register and
// restarts the load count; the sample store holds no reset value.
module real_input_dft #(
	parameter int POINTS      = rid_pkg::POINTS_DEF,
	parameter int SAMPLE_BITS = rid_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [rid_pkg::SAMPLE_W-1:0] sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic        [rid_pkg::BIN_W-1:0]    bin_number,
	output logic signed [rid_pkg::OUT_W-1:0]    real_part,
	output logic signed [rid_pkg::OUT_W-1:0]    imag_part,
	output logic                                final_bin
);

	localparam int IDX_W     = $clog2(POINTS);
	localparam int ROM_SHIFT = rid_pkg::ROM_AW - IDX_W;
	localparam int PROD_W    = SAMPLE_BITS + rid_pkg::TW_W;
	localparam int ACC_W     = PROD_W + IDX_W;
	localparam int EXT_W     = ACC_W + rid_pkg::OUT_W;
	localparam int OUT_LO    = rid_pkg::FRAC_BITS;
	localparam int OUT_HI    = rid_pkg::FRAC_BITS + rid_pkg::OUT_W - 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS - 1);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;

	// sequencer
	logic [IDX_W-1:0] load_q;
	logic [IDX_W-1:0] bin_q;
	logic [IDX_W-1:0] term_q;
	logic [IDX_W-1:0] phase_q;

	// sample store
	logic signed [SAMPLE_BITS-1:0] mem_q [POINTS];
	logic signed [SAMPLE_BITS-1:0] samp_in;

	// pipeline
	logic                          adv;
	logic                          issue;
	logic                          accept;
	logic [rid_pkg::ROM_AW-1:0]    rom_idx;
	logic                          valid_s1, first_s1, last_s1;
	logic [IDX_W-1:0]              bin_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic signed [rid_pkg::TW_W-1:0] cos_s1, sin_s1;
	logic                          valid_s2, first_s2, last_s2;
	logic [IDX_W-1:0]              bin_s2;
	logic signed [PROD_W-1:0]      mul_re, mul_im;
	logic signed [PROD_W-1:0]      prod_re_s2, prod_im_s2;
	logic signed [ACC_W-1:0]       acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0]       acc_re_nxt, acc_im_nxt;
	logic signed [EXT_W-1:0]       ext_re, ext_im;

	// result register
	logic                                out_valid_q;
	logic        [rid_pkg::BIN_W-1:0]    out_bin_q;
	logic signed [rid_pkg::OUT_W-1:0]    out_re_q, out_im_q;
	logic                                out_final_q;

	// low SAMPLE_BITS of the field; wider settings see the field zero-extended
	generate
		if (SAMPLE_BITS <= rid_pkg::SAMPLE_W) begin : g_narrow
			assign samp_in = sample[SAMPLE_BITS-1:0];
		end else begin : g_wide
			assign samp_in = SAMPLE_BITS'($unsigned(sample));
		end
	endgenerate

	assign sample_stall = (state_q != ST_LOAD);
	assign accept       = sample_valid && !sample_stall;

	// everything behind the sequencer moves only when the result register can take a bin
	assign adv     = !out_valid_q || !result_stall;
	assign issue   = (state_q == ST_RUN) && adv;
	assign rom_idx = rid_pkg::ROM_AW'(phase_q) << ROM_SHIFT;

	// sequencer: phase steps by the bin number each term, wraps mod 2**IDX_W (POINTS when a power of two)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q  <= '0;
			bin_q   <= '0;
			term_q  <= '0;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						load_q <= load_q + 1'b1;
						if (load_q == IDX_LAST) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (term_q == IDX_LAST) begin
							term_q  <= '0;
							phase_q <= '0;
							bin_q   <= bin_q + 1'b1;
							if (bin_q == IDX_LAST) begin
								state_q <= ST_LOAD;
							end
						end else begin
							term_q  <= term_q + 1'b1;
							phase_q <= phase_q + bin_q;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// sample store: written while loading, read while issuing terms
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[load_q] <= samp_in;
		end
		if (issue) begin
			rd_s1 <= mem_q[term_q];
		end
	end

	// stage 1: twiddle rom, stage 2: products
	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s1     <= rid_pkg::twiddle_cos(rom_idx);
			sin_s1     <= rid_pkg::twiddle_cos(rom_idx + rid_pkg::ROM_QTR);
			bin_s1     <= bin_q;
			first_s1   <= (term_q == '0);
			last_s1    <= (term_q == IDX_LAST);
			prod_re_s2 <= mul_re;
			prod_im_s2 <= mul_im;
			bin_s2     <= bin_s1;
			first_s2   <= first_s1;
			last_s2    <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	assign mul_re = rd_s1 * cos_s1;
	assign mul_im = rd_s1 * sin_s1;

	// stage 3: accumulate, the first term of a bin restarts the sum
	assign acc_re_nxt = first_s2 ? ACC_W'(prod_re_s2) : acc_re_q + ACC_W'(prod_re_s2);
	assign acc_im_nxt = first_s2 ? ACC_W'(prod_im_s2) : acc_im_q + ACC_W'(prod_im_s2);
	assign ext_re     = EXT_W'(acc_re_nxt);
	assign ext_im     = EXT_W'(acc_im_nxt);

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			acc_re_q <= acc_re_nxt;
			acc_im_q <= acc_im_nxt;
		end
		if (adv && valid_s2 && last_s2) begin
			out_bin_q   <= rid_pkg::BIN_W'(bin_s2);
			out_re_q    <= ext_re[OUT_HI:OUT_LO];
			out_im_q    <= ext_im[OUT_HI:OUT_LO];
			out_final_q <= (bin_s2 == IDX_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign bin_number   = out_bin_q;
	assign real_part    = out_re_q;
	assign imag_part    = out_im_q;
	assign final_bin    = out_final_q;

	// final flag marks exactly the last bin
	a_final_bin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (final_bin == (bin_number == rid_pkg::BIN_W'(POINTS - 1))))
		else $error("final_bin does not match the last bin number");

	// a held result freezes the term sequencer
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_stall) |=> ($stable(term_q) && $stable(bin_q)))
		else $error("sequencer moved while the result register was held");

	// issuing the last term of the last bin returns to loading
	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && term_q == IDX_LAST && bin_q == IDX_LAST)
		|=> (state_q == ST_LOAD && bin_q == '0 && term_q == '0))
		else $error("block did not return to loading after the last bin");

	// term and phase counters stay at zero while loading
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (term_q == '0 && phase_q == '0 && bin_q == '0))
		else $error("term counters not cleared while loading");

endmodule
